// ===== rtl/ckbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbs_pkg
// Shared types, constants and key tables for the counter-keyed byte stream
// cipher core.
// ----------------------------------------------------------------------------
package ckbs_pkg;

    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int KEY_DEPTH = 256;

    localparam logic [BYTE_W-1:0] DATA_MASK = 8'hAB;
    localparam logic [BYTE_W-1:0] KEY1_SEED = 8'h9D;
    localparam logic [BYTE_W-1:0] KEY2_SEED = 8'h62;

    // Direction select; it doubles as the counter memory address.
    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KEY_DEPTH-1:0][BYTE_W-1:0] key_tab_t;

    // Write port of the counter memory.
    typedef struct packed {
        logic en;
        op_t  addr;
        cnt_t data;
    } ctr_wr_t;

    // The tables are built at elaboration; they synthesize to constant ROMs.
    function automatic key_tab_t gen_key1();
        key_tab_t tab;
        byte_t    a;
        byte_t    ma;
        byte_t    mult;
        a = KEY1_SEED;
        for (int i = 0; i < KEY_DEPTH; i++)
        begin
            tab[i] = a;
            ma     = a * 8'hFA;
            mult   = 8'h0F + ma;
            a      = mult * a + 8'h13;
        end
        return tab;
    endfunction

    function automatic key_tab_t gen_key2();
        key_tab_t tab;
        byte_t    b;
        byte_t    mb;
        byte_t    mult;
        b = KEY2_SEED;
        for (int i = 0; i < KEY_DEPTH; i++)
        begin
            tab[i] = b;
            mb     = b * 8'h5C;
            mult   = 8'h79 - mb;
            b      = mult * b + 8'h6D;
        end
        return tab;
    endfunction

    localparam key_tab_t KEY1_TAB = gen_key1();
    localparam key_tab_t KEY2_TAB = gen_key2();

    // Input byte whitening: XOR with a constant, then swap the nibbles.
    function automatic byte_t whiten(input byte_t d);
        byte_t x;
        x = d ^ DATA_MASK;
        return {x[3:0], x[7:4]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/counter_keyed_byte_stream_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// counter_keyed_byte_stream_cipher_core
// Byte stream cipher with per-direction 16-bit counters and table keystream.
// ----------------------------------------------------------------------------
// The core takes one byte per clock unless stalled and returns its result
// through a stage-one register and an output register. The encrypt and
// decrypt counters live in a two-entry memory with a registered read: the
// count is read at acceptance, used and incremented while the byte is in
// stage one, and written back as it moves on; a bypass on the write port
// keeps consecutive bytes of the same direction correct at full rate. Both
// counters read as zero after reset without any clearing pass, so the core is ready immediately.
// ----------------------------------------------------------------------------
module counter_keyed_byte_stream_cipher_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_stall,
    input  wire logic opcode,
    input  wire logic [7:0] data_byte,
    input  wire logic buffer_end,
    output logic      result_valid,
    input  wire logic result_stall,
    output logic [7:0] out_byte,
    output logic      result_end
);
    import ckbs_pkg::*;

    logic    item_accept;
    logic    s1_go;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    op_t     s1_op_reg;
    byte_t   s1_data_reg;
    logic    s1_end_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    byte_t   out_byte_reg;
    logic    out_end_reg;
    cnt_t    cnt;
    byte_t   keystream;
    ctr_wr_t ctr_wr;

    assign s1_go       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && !s1_go;
    assign item_accept = item_valid && !item_stall;

    ckbs_ctr_mem u_ctr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (item_accept),
        .rd_addr (op_t'(opcode)),
        .wr      (ctr_wr),
        .rd_data (cnt)
    );

    ckbs_key_rom u_key_rom (
        .cnt       (cnt),
        .keystream (keystream)
    );

    always_comb
    begin
        ctr_wr.en   = s1_go;
        ctr_wr.addr = s1_op_reg;
        ctr_wr.data = cnt + cnt_t'(1);
    end

    always_comb
    begin
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_op_reg   <= op_t'(opcode);
            s1_data_reg <= whiten(data_byte);
            s1_end_reg  <= buffer_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_byte_reg <= s1_data_reg ^ keystream;
            out_end_reg  <= s1_end_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign result_end   = out_end_reg;

endmodule
`default_nettype wire

// ===== rtl/ckbs_ctr_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbs_ctr_mem
// Two-entry counter memory, one entry per direction, with a registered read,
// a same-cycle write bypass and per-entry valid bits that read as zero.
// ----------------------------------------------------------------------------
module ckbs_ctr_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire ckbs_pkg::op_t     rd_addr,
    input  wire ckbs_pkg::ctr_wr_t wr,
    output ckbs_pkg::cnt_t         rd_data
);
    import ckbs_pkg::*;

    cnt_t       mem [2];
    logic [1:0] valid_reg;
    logic [1:0] valid_next;
    cnt_t       rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // A read that hits the entry being written in the same cycle takes the
    // new value, so back-to-back bytes of one direction see fresh counts.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/ckbs_key_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbs_key_rom
// Keystream byte lookup: low counter byte indexes the first key table, high
// counter byte the second, and the two entries are combined by XOR.
// ----------------------------------------------------------------------------
module ckbs_key_rom (
    input  wire ckbs_pkg::cnt_t cnt,
    output ckbs_pkg::byte_t     keystream
);
    import ckbs_pkg::*;

    byte_t key1;
    byte_t key2;

    assign key1      = KEY1_TAB[cnt[7:0]];
    assign key2      = KEY2_TAB[cnt[15:8]];
    assign keystream = key1 ^ key2;

endmodule
`default_nettype wire

// ===== rtl/ckbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbs_checker
// Port-level checks on the cipher core's handshakes and latency.
// ----------------------------------------------------------------------------
module ckbs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] out_byte,
    input wire logic       result_end
);

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(out_byte) && $stable(result_end))
        else $error("result payload changed while stalled");

    // Every accepted transaction is followed by a valid result on the output.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##2 result_valid)
        else $error("accepted byte did not reach the output in time");

    // The input stalls only when a finished result is itself stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without output back-pressure");

    // A result appearing on an idle output comes from an earlier accepted
    // transaction; nothing is invented.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(rst_n && item_valid && !item_stall, 2))
        else $error("result appeared without an accepted byte");

endmodule

bind counter_keyed_byte_stream_cipher_core ckbs_checker u_ckbs_checker (.*);
`default_nettype wire
